// ===== design/kls_pkg.sv =====
// Shared constants and types for the k-th largest stream selector.
package kls_pkg;
	localparam int KMax = 64;
	localparam int IdxW = $clog2(KMax);
	localparam int CntW = $clog2(KMax + 1);
	localparam int KW = 7;
	localparam logic [0:0] RegKSelect = 1'b0;
	typedef logic signed [31:0] val_t;
endpackage

// ===== design/kls_store.sv =====
// Sorted value store: one-port-write, one-port-read synchronous memory.
module kls_store
	import kls_pkg::*;
(
	input  logic            clk,
	input  logic            we,
	input  logic [IdxW-1:0] waddr,
	input  val_t            wdata,
	input  logic [IdxW-1:0] raddr,
	output val_t            rdata
);
	val_t mem [KMax];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/kth_largest_stream_select_top.sv =====
// Top level of the k-th largest stream selector.
// Each beat carries one signed 32-bit value and tlast marking the end of an array. The block
// keeps the largest values seen (up to 64) sorted descending in one synchronous memory and
// inserts each value by walking from the bottom of the store upward, shifting smaller entries
// down one place per cycle through the single read and write port. When the store is full a
// value not above the bottom entry is dropped. On tlast one result beat gives the k-th largest
// value and an underfilled flag (set when the array held fewer than k values, k clamped to
// 1..64), read in the RES_RD and RES_WAIT states after the insert, and the store empties for
// the next array.
module kth_largest_stream_select_top
	import kls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // kth_value[31:0]
	output logic        m_tuser   // underfilled
);
	typedef enum logic [2:0] {IDLE, RD, CMP, RES_RD, RES_WAIT, OUT, FULL_CHK} state_t;

	state_t          state_q;
	logic [KW-1:0]   k_q;
	logic [CntW-1:0] cnt_q;
	val_t            key_q;
	logic            last_q;
	logic [IdxW-1:0] pos_q;
	logic            under_q;
	logic [31:0]     res_q;

	logic            we;
	logic [IdxW-1:0] waddr;
	val_t            wdata;
	logic [IdxW-1:0] raddr;
	val_t            rdata;
	logic [CntW-1:0] keff;

	kls_store u_store (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	assign pready   = 1'b1;
	assign prdata   = {{(32-KW){1'b0}}, k_q};
	assign s_tready = (state_q == IDLE);
	assign m_tvalid = (state_q == OUT);
	assign m_tdata  = res_q;
	assign m_tuser  = under_q;

	// Clamp k to 1..KMax
	always_comb begin
		if (k_q == '0) begin
			keff = CntW'(1);
		end else if (CntW'(k_q) > CntW'(KMax)) begin
			keff = CntW'(KMax);
		end else begin
			keff = CntW'(k_q);
		end
	end

	// Memory port steering
	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = key_q;
		raddr = pos_q - IdxW'(1);
		if (state_q == CMP) begin
			if (pos_q != '0 && rdata < key_q) begin
				// shift the smaller entry down one place
				we    = (CntW'(pos_q) < CntW'(KMax));
				wdata = rdata;
				raddr = pos_q - IdxW'(2);
			end else begin
				we = 1'b1;
			end
		end else if (state_q == RES_RD) begin
			raddr = (cnt_q >= keff) ? IdxW'(keff - CntW'(1)) : IdxW'(cnt_q - CntW'(1));
		end else if (state_q == IDLE) begin
			// read the bottom entry for a full store
			raddr = IdxW'(KMax - 1);
		end
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			k_q     <= KW'(1);
			cnt_q   <= '0;
			under_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == RegKSelect) begin
				k_q <= pwdata[KW-1:0];
			end
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						key_q  <= s_tdata;
						last_q <= s_tlast;
						// start at the slot just past the bottom entry, or at the bottom entry itself when full
						if (cnt_q == CntW'(KMax)) begin
							pos_q <= IdxW'(KMax - 1);
						end else begin
							pos_q <= IdxW'(cnt_q);
						end
						state_q <= (cnt_q == CntW'(KMax)) ? FULL_CHK : RD;
					end
				end
				RD: begin
					state_q <= CMP;
				end
				FULL_CHK: begin
					// full store: a key not above the bottom falls off
					if (rdata < key_q) begin
						state_q <= CMP;
					end else begin
						state_q <= last_q ? RES_RD : IDLE;
					end
				end
				CMP: begin
					if (pos_q != '0 && rdata < key_q) begin
						pos_q <= pos_q - IdxW'(1);
					end else begin
						if (cnt_q != CntW'(KMax)) begin
							cnt_q <= cnt_q + CntW'(1);
						end
						state_q <= last_q ? RES_RD : IDLE;
					end
				end
				RES_RD: begin
					under_q <= (cnt_q < keff);
					state_q <= RES_WAIT;
				end
				RES_WAIT: begin
					res_q   <= rdata;
					cnt_q   <= '0;
					state_q <= OUT;
				end
				OUT: begin
					if (m_tready) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== design/kls_checker.sv =====
// Port-level checker for the k-th largest stream selector.
module kls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result not held");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(m_tvalid && s_tready))
		else $error("input open while result pending");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");
endmodule

bind kth_largest_stream_select_top kls_checker u_kls_checker (
	.clk, .arst_n, .pready, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
